/* hw/rtl/drwp_pkg.sv */
`timescale 1ns / 1ps

package drwp_pkg;

  // Radix register limits and reset value.
  localparam logic [4:0] DigitBaseReset = 5'd10;
  localparam logic [4:0] DigitBaseMin   = 5'd2;
  localparam logic [4:0] DigitBaseMax   = 5'd16;

  // Saturation points of the digit counters and totals.
  localparam logic [6:0]  CountSat = 7'd127;
  localparam logic [15:0] TotalSat = 16'hFFFF;

  // One input request.
  typedef struct packed {
    logic [3:0] digit_value;
    logic       run_end;
    logic       drop_trailing_zeros;
    logic       start_new_number;
  } drwp_in_t;

  // One result.
  typedef struct packed {
    logic [63:0] part_word;
    logic [6:0]  part_digit_count;
    logic        part_stored;
    logic        table_full;
    logic [15:0] stored_digit_total;
    logic [15:0] scanned_digit_total;
    logic        run_last;
  } drwp_out_t;

  // A classified command passed from the front to the back.
  typedef struct packed {
    logic [3:0] digit;
    logic       is_end;
    logic       drop;
    logic       fresh;
    logic [4:0] base;
  } drwp_cmd_t;

endpackage

/* hw/rtl/drwp_front.sv */
`timescale 1ns / 1ps

module drwp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [4:0]          base_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  drwp_pkg::drwp_in_t  in_data_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output drwp_pkg::drwp_cmd_t cmd_o
);
  import drwp_pkg::*;

  logic      valid_d, valid_q;
  drwp_cmd_t cmd_d, cmd_q;
  logic [4:0] base_eff;
  logic       keep;

  // Clamp the radix into its legal range.
  always_comb begin
    if (base_i < DigitBaseMin) begin
      base_eff = DigitBaseMin;
    end else if (base_i > DigitBaseMax) begin
      base_eff = DigitBaseMax;
    end else begin
      base_eff = base_i;
    end
  end

  // A digit that is not below the radix is discarded here and never queued.
  assign keep = in_data_i.run_end || ({1'b0, in_data_i.digit_value} < base_eff);

  assign in_ready_o = !valid_q || cmd_ready_i;

  always_comb begin
    cmd_d   = cmd_q;
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d     = keep;
      cmd_d.digit = in_data_i.digit_value;
      cmd_d.is_end = in_data_i.run_end;
      cmd_d.drop  = in_data_i.drop_trailing_zeros;
      cmd_d.fresh = in_data_i.start_new_number;
      cmd_d.base  = base_eff;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Command payload.
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

/* hw/rtl/drwp_queue.sv */
`timescale 1ns / 1ps

module drwp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  drwp_pkg::drwp_cmd_t push_data_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output drwp_pkg::drwp_cmd_t pop_data_o
);
  import drwp_pkg::*;

  localparam int unsigned QDepth = 2;

  drwp_cmd_t  slot_q [QDepth];
  logic       wr_ptr_d, wr_ptr_q;
  logic       rd_ptr_d, rd_ptr_q;
  logic [1:0] count_d, count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'(QDepth));
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = slot_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage slots.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* hw/rtl/drwp_back.sv */
`timescale 1ns / 1ps

module drwp_back #(
  parameter int unsigned MAX_PARTS = 8,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  drwp_pkg::drwp_cmd_t cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output drwp_pkg::drwp_out_t out_data_o
);
  import drwp_pkg::*;

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned PW = $clog2(MAX_PARTS + 1);

  // Part and run state.
  logic [W-1:0]  acc_d, acc_q;
  logic [W-1:0]  valnz_d, valnz_q;
  logic [6:0]    pd_d, pd_q;
  logic [6:0]    tz_d, tz_q;
  logic [PW-1:0] spc_d, spc_q;
  logic [15:0]   kept_d, kept_q;
  logic [15:0]   rsum_d, rsum_q;
  logic          full_d, full_q;
  logic          out_valid_d, out_valid_q;
  drwp_out_t     out_d, out_q;

  logic [W+4:0]  prod;
  logic          ovf, has_res, out_free, pop;
  logic [W-1:0]  offer_word;
  logic [6:0]    offer_cnt;
  logic          take;
  logic [16:0]   kept_sum;
  logic [15:0]   rsum_inc;
  logic [6:0]    pd_inc, tz_inc;

  // Next accumulator value at full width; any bit above the word means overflow.
  assign prod = {5'b0, acc_q} * {{W{1'b0}}, cmd_i.base} + {{(W + 1){1'b0}}, cmd_i.digit};
  assign ovf  = |prod[W+4:W];

  assign has_res     = cmd_i.is_end || ovf;
  assign out_free    = !out_valid_q || out_ready_i;
  assign pop         = cmd_valid_i && (!has_res || out_free);
  assign cmd_ready_o = !has_res || out_free;

  assign rsum_inc = (rsum_q == TotalSat) ? rsum_q : rsum_q + 16'd1;
  assign pd_inc   = (pd_q == CountSat) ? pd_q : pd_q + 7'd1;
  assign tz_inc   = (tz_q == CountSat) ? tz_q : tz_q + 7'd1;

  // Part offered to the table: the stripped or full part on a run end,
  // the finished part on overflow.
  always_comb begin
    if (cmd_i.is_end && cmd_i.drop) begin
      offer_word = valnz_q;
      offer_cnt  = pd_q - tz_q;
    end else begin
      offer_word = acc_q;
      offer_cnt  = pd_q;
    end
  end

  // Table acceptance rules.
  always_comb begin
    take   = 1'b0;
    full_d = full_q;
    if (has_res && offer_cnt != 7'd0) begin
      if (spc_q == '0) begin
        take = (offer_word != '0);
      end else if (spc_q >= PW'(MAX_PARTS)) begin
        full_d = 1'b1;
      end else begin
        take = 1'b1;
      end
    end
  end

  assign kept_sum = {1'b0, kept_q} + {10'd0, offer_cnt};

  // State update and result formation.
  always_comb begin
    acc_d       = acc_q;
    valnz_d     = valnz_q;
    pd_d        = pd_q;
    tz_d        = tz_q;
    spc_d       = spc_q;
    kept_d      = kept_q;
    rsum_d      = rsum_q;
    out_d       = out_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;

    if (take) begin
      spc_d  = spc_q + PW'(1);
      kept_d = kept_sum[16] ? TotalSat : kept_sum[15:0];
    end

    if (cmd_i.is_end) begin
      // Result shows the run total before it is cleared.
      acc_d   = '0;
      valnz_d = '0;
      pd_d    = 7'd0;
      tz_d    = 7'd0;
      rsum_d  = 16'd0;
    end else if (ovf) begin
      // The digit starts a fresh part.
      acc_d   = W'(cmd_i.digit);
      valnz_d = W'(cmd_i.digit);
      pd_d    = 7'd1;
      tz_d    = (cmd_i.digit == 4'd0) ? 7'd1 : 7'd0;
      rsum_d  = rsum_inc;
    end else begin
      acc_d  = prod[W-1:0];
      pd_d   = pd_inc;
      rsum_d = rsum_inc;
      if (cmd_i.digit != 4'd0) begin
        tz_d    = 7'd0;
        valnz_d = prod[W-1:0];
      end else begin
        tz_d = tz_inc;
      end
    end

    out_d.part_word           = 64'(offer_word);
    out_d.part_digit_count    = offer_cnt;
    out_d.part_stored         = take;
    out_d.table_full          = full_d;
    out_d.stored_digit_total  = kept_d;
    out_d.scanned_digit_total = cmd_i.is_end ? rsum_q : rsum_inc;
    out_d.run_last            = cmd_i.is_end;

    // The result register only loads when a result is produced, so a
    // waiting result keeps its payload while plain digits pass.
    if (pop && has_res) begin
      out_valid_d = 1'b1;
    end else begin
      out_d = out_q;
    end

    // A fresh number clears the table bookkeeping after its result.
    if (pop && cmd_i.is_end && cmd_i.fresh) begin
      spc_d  = '0;
      kept_d = 16'd0;
    end
  end

  // Control and accumulated state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      valnz_q     <= '0;
      pd_q        <= 7'd0;
      tz_q        <= 7'd0;
      spc_q       <= '0;
      kept_q      <= 16'd0;
      rsum_q      <= 16'd0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop) begin
        acc_q   <= acc_d;
        valnz_q <= valnz_d;
        pd_q    <= pd_d;
        tz_q    <= tz_d;
        spc_q   <= spc_d;
        kept_q  <= kept_d;
        rsum_q  <= rsum_d;
        full_q  <= (cmd_i.is_end && cmd_i.fresh) ? 1'b0 : full_d;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hw/rtl/digit_run_to_word_parts_unit.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// cfg       in         cfg_we_i                  cfg_wdata_i (digit_base, 5 bits)
// in        in         in_valid_i / in_ready_o   in_data_i  (drwp_in_t)
// out       out        out_valid_o / out_ready_i out_data_o (drwp_out_t)
//
// One request per cycle is sustained while no result waits on a stalled output;
// the limit is the back end's multiply-by-radix loop on the accumulator.
// An accepted request passes the front register, a queue slot and then the result
// register before its result is valid.
// Reset is asynchronous and active low; the radix resets to ten.
// A stalled output holds only requests that produce a result; the queue and front
// register keep taking requests until they fill.

module digit_run_to_word_parts_unit #(
  parameter int unsigned MAX_PARTS = 8,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [4:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  drwp_pkg::drwp_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output drwp_pkg::drwp_out_t out_data_o
);
  import drwp_pkg::*;

  logic [4:0] base_q;
  logic       f_valid, f_ready;
  drwp_cmd_t  f_cmd;
  logic       b_valid, b_ready;
  drwp_cmd_t  b_cmd;

  // Radix register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= DigitBaseReset;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  drwp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .base_i      (base_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  drwp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_cmd),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_cmd)
  );

  drwp_back #(
    .MAX_PARTS (MAX_PARTS),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .cmd_i       (b_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // A stored part always carries digits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.part_stored |-> out_data_o.part_digit_count != 7'd0)
    else $error("stored part without digits");

  // A stored part leaves a nonzero stored total.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.part_stored |-> out_data_o.stored_digit_total != 16'd0)
    else $error("stored total is zero after a stored part");

  // An overflow emission counts the digit that caused it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.run_last |-> out_data_o.scanned_digit_total != 16'd0)
    else $error("overflow result with empty scan total");

endmodule

/* tb/digit_run_to_word_parts_unit_test.sv */
`timescale 1ns / 1ps

module digit_run_to_word_parts_unit_test;
  import drwp_pkg::*;

  localparam int unsigned MaxParts   = 8;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned DrainWait  = 8;

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_we_i;
  logic [4:0] cfg_wdata_i;
  logic      in_valid_i;
  logic      in_ready_o;
  drwp_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  drwp_out_t out_data_o;

  digit_run_to_word_parts_unit #(
    .MAX_PARTS(MaxParts),
    .WORD_BITS(64)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Predicted state of the block.
  logic [4:0]  radix_q;
  logic [63:0] acc_q;
  logic [63:0] last_nz_q;
  logic [6:0]  digits_q;
  logic [6:0]  tz_q;
  logic [4:0]  parts_q;
  logic [15:0] kept_q;
  logic [15:0] scanned_q;
  logic        full_q;

  drwp_out_t   expected_parts[$];
  drwp_out_t   want_part;
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned stall_left;
  bit          idle_on;

  // Free-running clock.
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // A hung run ends here.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  function automatic logic [4:0] clamp_radix(input logic [4:0] r);
    if (r < DigitBaseMin) return DigitBaseMin;
    if (r > DigitBaseMax) return DigitBaseMax;
    return r;
  endfunction

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? TotalSat : s[15:0];
  endfunction

  function automatic void clear_part_state();
    acc_q     = '0;
    last_nz_q = '0;
    digits_q  = '0;
    tz_q      = '0;
  endfunction

  // Offers a finished part to the parts table and returns whether it was kept.
  function automatic logic offer_part(input logic [63:0] word, input logic [6:0] count);
    if (count == 0) return 1'b0;
    if (parts_q == 0) begin
      if (word == 0) return 1'b0;
    end else if (parts_q >= MaxParts) begin
      full_q = 1'b1;
      return 1'b0;
    end
    parts_q = parts_q + 5'd1;
    kept_q  = sat_add16(kept_q, {9'd0, count});
    return 1'b1;
  endfunction

  // Folds one digit into the running part.
  function automatic void take_digit(input logic [4:0] b, input logic [3:0] d);
    acc_q = acc_q * {59'd0, b} + {60'd0, d};
    if (digits_q < CountSat) digits_q = digits_q + 7'd1;
    if (d != 0) begin
      tz_q      = '0;
      last_nz_q = acc_q;
    end else if (tz_q < CountSat) begin
      tz_q = tz_q + 7'd1;
    end
    scanned_q = sat_add16(scanned_q, 16'd1);
  endfunction

  function automatic void reset_predictor();
    radix_q = DigitBaseReset;
    clear_part_state();
    parts_q   = '0;
    kept_q    = '0;
    scanned_q = '0;
    full_q    = 1'b0;
  endfunction

  // Works out the result, if any, that an accepted request causes.
  task automatic predict_request(input drwp_in_t req);
    logic [4:0]  b;
    logic [63:0] word;
    logic [63:0] cutoff;
    logic [63:0] cutlim;
    logic [6:0]  count;
    logic        stored;
    drwp_out_t   res;
    b = clamp_radix(radix_q);
    if (req.run_end) begin
      if (req.drop_trailing_zeros) begin
        word  = last_nz_q;
        count = digits_q - tz_q;
      end else begin
        word  = acc_q;
        count = digits_q;
      end
      stored = offer_part(word, count);
      res.part_word           = word;
      res.part_digit_count    = count;
      res.part_stored         = stored;
      res.table_full          = full_q;
      res.stored_digit_total  = kept_q;
      res.scanned_digit_total = scanned_q;
      res.run_last            = 1'b1;
      expected_parts.push_back(res);
      clear_part_state();
      scanned_q = '0;
      if (req.start_new_number) begin
        parts_q = '0;
        kept_q  = '0;
        full_q  = 1'b0;
      end
    end else if ({1'b0, req.digit_value} < b) begin
      cutoff = 64'hFFFF_FFFF_FFFF_FFFF / {59'd0, b};
      cutlim = 64'hFFFF_FFFF_FFFF_FFFF % {59'd0, b};
      if (acc_q > cutoff || (acc_q == cutoff && {60'd0, req.digit_value} > cutlim)) begin
        // The digit does not fit: emit the part and start a new one with it.
        word   = acc_q;
        count  = digits_q;
        stored = offer_part(word, count);
        clear_part_state();
        take_digit(b, req.digit_value);
        res.part_word           = word;
        res.part_digit_count    = count;
        res.part_stored         = stored;
        res.table_full          = full_q;
        res.stored_digit_total  = kept_q;
        res.scanned_digit_total = scanned_q;
        res.run_last            = 1'b0;
        expected_parts.push_back(res);
      end else begin
        take_digit(b, req.digit_value);
      end
    end
  endtask

  // Receiver side: ready drops in random bursts while idling is enabled.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 7) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Each accepted result is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_parts.size() == 0) begin
        report_mismatch($sformatf("result with no request pending, word %0h",
                                  out_data_o.part_word));
      end else begin
        want_part = expected_parts.pop_front();
        if (out_data_o.part_word !== want_part.part_word)
          report_mismatch($sformatf("part_word got %0h expected %0h",
                                    out_data_o.part_word, want_part.part_word));
        if (out_data_o.part_digit_count !== want_part.part_digit_count)
          report_mismatch($sformatf("part_digit_count got %0d expected %0d",
                                    out_data_o.part_digit_count,
                                    want_part.part_digit_count));
        if (out_data_o.part_stored !== want_part.part_stored)
          report_mismatch($sformatf("part_stored got %0b expected %0b",
                                    out_data_o.part_stored, want_part.part_stored));
        if (out_data_o.table_full !== want_part.table_full)
          report_mismatch($sformatf("table_full got %0b expected %0b",
                                    out_data_o.table_full, want_part.table_full));
        if (out_data_o.stored_digit_total !== want_part.stored_digit_total)
          report_mismatch($sformatf("stored_digit_total got %0d expected %0d",
                                    out_data_o.stored_digit_total,
                                    want_part.stored_digit_total));
        if (out_data_o.scanned_digit_total !== want_part.scanned_digit_total)
          report_mismatch($sformatf("scanned_digit_total got %0d expected %0d",
                                    out_data_o.scanned_digit_total,
                                    want_part.scanned_digit_total));
        if (out_data_o.run_last !== want_part.run_last)
          report_mismatch($sformatf("run_last got %0b expected %0b",
                                    out_data_o.run_last, want_part.run_last));
      end
    end
  end

  // Sends one request; called and returns at a falling edge.
  task automatic send_request(input drwp_in_t req);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_request(req);
    @(negedge clk_i);
  endtask

  function automatic drwp_in_t make_digit(input logic [3:0] d);
    drwp_in_t r;
    r.digit_value         = d;
    r.run_end             = 1'b0;
    r.drop_trailing_zeros = 1'($urandom_range(0, 1));
    r.start_new_number    = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic drwp_in_t make_end(input logic drop, input logic fresh);
    drwp_in_t r;
    r.digit_value         = 4'($urandom_range(0, 15));
    r.run_end             = 1'b1;
    r.drop_trailing_zeros = drop;
    r.start_new_number    = fresh;
    return r;
  endfunction

  // Stops sending and waits until every expected result has come back,
  // then lets digits still in flight settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_parts.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic set_radix(input logic [4:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    radix_q = value;
  endtask

  task automatic send_decimal(input string digits);
    for (int i = 0; i < digits.len(); i++) begin
      send_request(make_digit(4'(digits.getc(i) - 8'd48)));
    end
  endtask

  // Reset radix: empty run, zero first part, trailing zeros, ignored digits.
  task automatic test_basic_runs();
    drwp_in_t r;
    r = make_end(1'b1, 1'b0);
    r.digit_value = 4'hF;
    send_request(r);
    send_request(make_digit(4'd0));
    send_request(make_end(1'b0, 1'b0));
    send_request(make_digit(4'd1));
    send_request(make_digit(4'd2));
    send_request(make_digit(4'd0));
    send_request(make_digit(4'd0));
    send_request(make_end(1'b1, 1'b0));
    send_request(make_digit(4'd9));
    send_request(make_digit(4'hA));
    send_request(make_digit(4'hF));
    send_request(make_end(1'b0, 1'b1));
    send_request(make_digit(4'd0));
    send_request(make_digit(4'd0));
    send_request(make_digit(4'd7));
    send_request(make_digit(4'd0));
    send_request(make_end(1'b1, 1'b1));
  endtask

  // Word overflow at both radix extremes, the exact decimal limit,
  // and filling the parts table until the full flag sticks.
  task automatic test_part_overflow();
    set_radix(DigitBaseMax);
    for (int p = 0; p < MaxParts + 2; p++) begin
      send_request(make_digit(4'($urandom_range(1, 15))));
      for (int i = 1; i < 16; i++) send_request(make_digit(4'($urandom_range(0, 15))));
    end
    send_request(make_end(1'b0, 1'b0));
    send_request(make_digit(4'd5));
    send_request(make_end(1'b0, 1'b1));
    send_request(make_digit(4'd3));
    send_request(make_end(1'b1, 1'b1));

    set_radix(DigitBaseMin);
    for (int i = 0; i < 65; i++) send_request(make_digit(4'd1));
    send_request(make_digit(4'd0));
    send_request(make_end(1'b1, 1'b1));

    set_radix(DigitBaseReset);
    send_decimal("18446744073709551615");
    send_request(make_end(1'b0, 1'b0));
    send_decimal("18446744073709551616");
    send_request(make_end(1'b0, 1'b0));
    send_decimal("184467440737095516150");
    send_request(make_end(1'b1, 1'b1));
  endtask

  // One well-formed run: random length and digits below the radix, then an end.
  task automatic send_random_run(output int unsigned taken);
    int unsigned len;
    int unsigned sel;
    int unsigned top;
    bit          zero_heavy;
    logic [3:0]  d;
    top = int'(clamp_radix(radix_q)) - 1;
    sel = $urandom_range(0, 9);
    if (sel < 7) len = $urandom_range(0, 12);
    else if (sel < 9) len = $urandom_range(13, 30);
    else len = $urandom_range(31, 70);
    zero_heavy = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      if (zero_heavy && $urandom_range(0, 9) < 7) d = 4'd0;
      else d = 4'($urandom_range(0, top));
      send_request(make_digit(d));
    end
    send_request(make_end(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0));
    taken = len + 1;
  endtask

  // Mostly well-formed runs, with some loose requests that may be ignored.
  task automatic run_random_phase(input int unsigned items);
    int unsigned sent;
    int unsigned taken;
    drwp_in_t    r;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 4) != 0) begin
        send_random_run(taken);
        sent += taken;
      end else begin
        r.digit_value         = 4'($urandom_range(0, 15));
        r.run_end             = ($urandom_range(0, 4) == 0);
        r.drop_trailing_zeros = 1'($urandom_range(0, 1));
        r.start_new_number    = 1'($urandom_range(0, 1));
        if (r.run_end || {1'b0, r.digit_value} < clamp_radix(radix_q)) sent++;
        send_request(r);
      end
    end
  endtask

  // Each radix setting is entered from an empty pipeline.
  task automatic test_random_runs();
    logic [4:0] radix_list[10];
    radix_list = '{5'd10, 5'd16, 5'd2, 5'd0, 5'd31, 5'd7, 5'd17, 5'd1, 5'd5, 5'd12};
    for (int k = 0; k < 10; k++) begin
      set_radix(radix_list[k]);
      run_random_phase(6);
    end
  endtask

  // A long zero run saturates the part digit counters.
  task automatic test_counter_saturation();
    idle_on = 1'b0;
    set_radix(DigitBaseReset);
    for (int i = 0; i < 135; i++) send_request(make_digit(4'd0));
    send_request(make_end(1'b0, 1'b1));
    send_request(make_digit(4'd4));
    send_request(make_digit(4'd0));
    send_request(make_end(1'b1, 1'b1));
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b1;
    stall_left  = 0;
    idle_on     = 1'b1;
    error_count = 0;
    reset_predictor();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_basic_runs();
    test_part_overflow();
    test_random_runs();
    test_counter_saturation();

    wait_drained();
    if (expected_parts.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_parts.size()));
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
